// File: sv/rwc_pkg.sv
// Shared types, constants and helper functions for the RGB window convolution core.
// Used by rgb_window_convolution_core; depends on nothing else.

package rwc_pkg;

    // Sizing
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 5;
    localparam int MAX_HEIGHT = 4096;
    localparam int KSIZE      = MAX_KERNEL * MAX_KERNEL;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KER_W  = $clog2(MAX_KERNEL + 1);

    // Register and field widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int KD_W       = 3;
    localparam int KIDX_W     = 5;
    localparam int COEF_W     = 16;
    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;

    // Datapath widths
    localparam int PROD_W   = COEF_W + PIX_W;
    localparam int ROWSUM_W = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int SUM_W    = ROWSUM_W + $clog2(MAX_KERNEL + 1);
    localparam int FRAC_W   = 14;
    localparam int PIX_MAX  = (1 << PIX_W) - 1;

    // Register reset values
    localparam logic [IW_W-1:0] IMAGE_WIDTH_RST   = IW_W'(640);
    localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST  = IH_W'(480);
    localparam logic [KD_W-1:0] KERNEL_WIDTH_RST  = KD_W'(5);
    localparam logic [KD_W-1:0] KERNEL_HEIGHT_RST = KD_W'(5);

    // Item kinds
    localparam logic KIND_COEF  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_KERNEL_WIDTH  = 2'd2,
        CFG_KERNEL_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                     kind;
        logic [KIDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic [PIX_W-1:0]         red_in;
        logic [PIX_W-1:0]         green_in;
        logic [PIX_W-1:0]         blue_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_last;
    } out_item_t;

    // Channel 0 is red, 1 green, 2 blue
    typedef logic [NUM_CH-1:0][PIX_W-1:0] rgb_t;

    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ROWSUM_W-1:0] rowsum_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // Line slot that holds the row 'off' rows above the one in 'slot'
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
                                                    input logic [KER_W-1:0]  off);
        logic [SLOT_W:0] t;
        t = (SLOT_W+1)'(slot) + (SLOT_W+1)'(MAX_KERNEL) - (SLOT_W+1)'(off);
        if (t >= (SLOT_W+1)'(MAX_KERNEL)) begin
            t = t - (SLOT_W+1)'(MAX_KERNEL);
        end
        return t[SLOT_W-1:0];
    endfunction

    // Q.14 sum -> round half up -> clip to 0..255
    function automatic logic [PIX_W-1:0] round_sat(input sum_t s);
        logic signed [SUM_W:0]  t;
        logic [SUM_W-FRAC_W:0]  q;
        t = $signed({s[SUM_W-1], s}) + $signed((SUM_W+1)'(1 << (FRAC_W - 1)));
        q = t[SUM_W:FRAC_W];
        if (t[SUM_W]) begin
            return '0;
        end else if (q > (SUM_W-FRAC_W+1)'(PIX_MAX)) begin
            return '1;
        end else begin
            return q[PIX_W-1:0];
        end
    endfunction

endpackage

// File: sv/rgb_window_convolution_core.sv
// Valid-mode 2D convolution of a raster RGB stream with one shared Q2.14 kernel.
// Depends on rwc_pkg (types, widths, slot_back, round_sat).
//
//   channel   ports                                   carries
//   -------   -------------------------------------   ------------------------------------
//   input     s_valid / s_ready / s_item (in_item_t)  coefficient load or one pixel
//   result    m_valid / m_ready / m_item (out_item_t) filtered pixel, frame_last flag
//   config    cfg_valid / cfg_ready / cfg_index /     image/kernel size registers
//             cfg_data
//
// One item accepted per clock when nothing stalls. Six registers lie between input and
// result (input reg, window, multiply, row sum, total, output reg); m_valid rises once
// the pixel closing its window has passed through all six. The 75 lane multiplies run
// in parallel, so rate is set by the line store's single write plus read per cycle.
// Each stage advances when the next one is empty or moving, so bubbles let input items
// in while a result waits.
// Reset (aresetn, synchronous) clears counters and valids and returns config to
// 640x480 with a 5x5 kernel; line store, window and kernel come up unset and need no
// clearing pass.

module rgb_window_convolution_core
    import rwc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers and effective (clamped) sizes
    // ------------------------------------------------------------------
    logic [IW_W-1:0] image_width_reg;
    logic [IH_W-1:0] image_height_reg;
    logic [KD_W-1:0] kernel_width_reg;
    logic [KD_W-1:0] kernel_height_reg;

    logic [IW_W-1:0]  w_eff;
    logic [IH_W-1:0]  h_eff;
    logic [KER_W-1:0] kw_clamp;
    logic [KER_W-1:0] kh_clamp;
    logic [KER_W-1:0] fw_eff;
    logic [KER_W-1:0] fh_eff;

    logic cfg_accept;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = IW_W'(1);
        end else if (image_width_reg > IW_W'(MAX_WIDTH)) begin
            w_eff = IW_W'(MAX_WIDTH);
        end else begin
            w_eff = image_width_reg;
        end

        if (image_height_reg == '0) begin
            h_eff = IH_W'(1);
        end else if (image_height_reg > IH_W'(MAX_HEIGHT)) begin
            h_eff = IH_W'(MAX_HEIGHT);
        end else begin
            h_eff = image_height_reg;
        end

        if (kernel_width_reg == '0) begin
            kw_clamp = KER_W'(1);
        end else if (KER_W'(kernel_width_reg) > KER_W'(MAX_KERNEL)) begin
            kw_clamp = KER_W'(MAX_KERNEL);
        end else begin
            kw_clamp = KER_W'(kernel_width_reg);
        end

        if (kernel_height_reg == '0) begin
            kh_clamp = KER_W'(1);
        end else if (KER_W'(kernel_height_reg) > KER_W'(MAX_KERNEL)) begin
            kh_clamp = KER_W'(MAX_KERNEL);
        end else begin
            kh_clamp = KER_W'(kernel_height_reg);
        end

        // kernel never wider/taller than the image
        fw_eff = (IW_W'(kw_clamp) > w_eff) ? w_eff[KER_W-1:0] : kw_clamp;
        fh_eff = (IH_W'(kh_clamp) > h_eff) ? h_eff[KER_W-1:0] : kh_clamp;
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the next is free or moving
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic m_valid_reg;
    logic out_en, s5_en, s4_en, s3_en, s2_en, s1_en;

    assign out_en = !m_valid_reg  || m_ready;
    assign s5_en  = !s5_valid_reg || out_en;
    assign s4_en  = !s4_valid_reg || s5_en;
    assign s3_en  = !s3_valid_reg || s4_en;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign s_ready = s1_en;

    logic in_accept;
    logic pix_accept;

    assign in_accept  = s_valid && s_ready;
    assign pix_accept = in_accept && (s_item.kind == KIND_PIXEL);

    // ------------------------------------------------------------------
    // Raster position: column, row and line slot (row mod MAX_KERNEL)
    // ------------------------------------------------------------------
    logic [COL_W-1:0]  column_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [IW_W-1:0] col_plus;
    logic [IH_W-1:0] row_plus;
    logic            row_end;
    logic            frame_end;
    logic            pix_last;
    logic            pix_emit;

    assign col_plus  = IW_W'(column_count_reg) + IW_W'(1);
    assign row_plus  = IH_W'(row_count_reg) + IH_W'(1);
    assign row_end   = col_plus >= w_eff;
    assign frame_end = row_plus >= h_eff;
    assign pix_last  = (col_plus == w_eff) && (row_plus == h_eff);
    // window complete once enough rows and columns have arrived
    assign pix_emit  = (row_plus >= IH_W'(fh_eff)) && (col_plus >= IW_W'(fw_eff));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= IMAGE_WIDTH_RST;
            image_height_reg  <= IMAGE_HEIGHT_RST;
            kernel_width_reg  <= KERNEL_WIDTH_RST;
            kernel_height_reg <= KERNEL_HEIGHT_RST;
            column_count_reg  <= '0;
            row_count_reg     <= '0;
            slot_reg          <= '0;
        end else if (cfg_accept) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[IH_W-1:0];
                CFG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[KD_W-1:0];
                CFG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[KD_W-1:0];
                default: ;
            endcase
            // any register write restarts the frame
            column_count_reg <= '0;
            row_count_reg    <= '0;
            slot_reg         <= '0;
        end else if (pix_accept) begin
            if (row_end) begin
                column_count_reg <= '0;
                if (frame_end) begin
                    row_count_reg <= '0;
                    slot_reg      <= '0;
                end else begin
                    row_count_reg <= row_plus[ROW_W-1:0];
                    slot_reg      <= (slot_reg == SLOT_W'(MAX_KERNEL - 1)) ?
                                     '0 : slot_reg + SLOT_W'(1);
                end
            end else begin
                column_count_reg <= col_plus[COL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: one memory per line slot. The current slot is written at
    // the current column; all slots are read there in the same cycle.
    // ------------------------------------------------------------------
    rgb_t pix_in;
    rgb_t rd_data [MAX_KERNEL];

    assign pix_in = {s_item.blue_in, s_item.green_in, s_item.red_in};

    for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_line
        rgb_t line_mem [MAX_WIDTH];
        rgb_t rd_reg;

        always_ff @(posedge aclk) begin
            if (pix_accept && (slot_reg == SLOT_W'(k))) begin
                line_mem[column_count_reg] <= pix_in;
            end
            if (in_accept) begin
                rd_reg <= line_mem[column_count_reg];
            end
        end

        assign rd_data[k] = rd_reg;
    end

    // ------------------------------------------------------------------
    // Stage 1: accepted item plus position flags
    // ------------------------------------------------------------------
    logic                     s1_pix_reg;
    logic [KIDX_W-1:0]        s1_coef_index_reg;
    logic signed [COEF_W-1:0] s1_coef_value_reg;
    rgb_t                     s1_pixel_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;
    logic                     s1_emit_reg;
    logic                     s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pix_reg        <= (s_item.kind == KIND_PIXEL);
            s1_coef_index_reg <= s_item.coef_index;
            s1_coef_value_reg <= s_item.coef_value;
            s1_pixel_reg      <= pix_in;
            s1_slot_reg       <= slot_reg;
            s1_emit_reg       <= pix_emit;
            s1_last_reg       <= pix_last;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window. Row kr of the window already lines up with kernel
    // row kr; new columns enter at column fw-1 and shift toward column 0,
    // so window column kc lines up with kernel column kc.
    // ------------------------------------------------------------------
    rgb_t newcol [MAX_KERNEL];
    rgb_t win_reg [MAX_KERNEL][MAX_KERNEL];

    logic                     s2_pix_reg;
    logic [KIDX_W-1:0]        s2_coef_index_reg;
    logic signed [COEF_W-1:0] s2_coef_value_reg;
    logic                     s2_emit_reg;
    logic                     s2_last_reg;

    always_comb begin
        logic [KER_W-1:0] off;
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            off = fh_eff - KER_W'(1) - KER_W'(kr);
            if (KER_W'(kr) >= fh_eff) begin
                newcol[kr] = '0;
            end else if (off == '0) begin
                newcol[kr] = s1_pixel_reg;
            end else begin
                newcol[kr] = rd_data[slot_back(s1_slot_reg, off)];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en && s1_valid_reg) begin
            s2_pix_reg        <= s1_pix_reg;
            s2_coef_index_reg <= s1_coef_index_reg;
            s2_coef_value_reg <= s1_coef_value_reg;
            s2_emit_reg       <= s1_emit_reg;
            s2_last_reg       <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en && s1_valid_reg && s1_pix_reg) begin
            for (int kr = 0; kr < MAX_KERNEL; kr++) begin
                for (int j = 0; j < MAX_KERNEL; j++) begin
                    if (KER_W'(j) == fw_eff - KER_W'(1)) begin
                        win_reg[kr][j] <= newcol[kr];
                    end else if (j < MAX_KERNEL - 1) begin
                        win_reg[kr][j] <= win_reg[kr][(j < MAX_KERNEL - 1) ? j + 1 : j];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Kernel store: written as a coefficient item leaves stage 2, so pixels
    // ahead of it still see the old kernel and pixels behind see the new.
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] kernel_reg [KSIZE];

    always_ff @(posedge aclk) begin
        if (s3_en && s2_valid_reg && !s2_pix_reg) begin
            for (int i = 0; i < KSIZE; i++) begin
                if (s2_coef_index_reg == KIDX_W'(i)) begin
                    kernel_reg[i] <= s2_coef_value_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: one multiplier per kernel tap and channel
    // ------------------------------------------------------------------
    prod_t prod_next [KSIZE][NUM_CH];
    prod_t prod_reg  [KSIZE][NUM_CH];
    logic  s3_last_reg;

    always_comb begin
        logic signed [PROD_W:0] full;
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    full = kernel_reg[kr*MAX_KERNEL + kc] *
                           $signed({1'b0, win_reg[kr][kc][ch]});
                    if ((KER_W'(kr) < fh_eff) && (KER_W'(kc) < fw_eff)) begin
                        prod_next[kr*MAX_KERNEL + kc][ch] = $signed(full[PROD_W-1:0]);
                    end else begin
                        prod_next[kr*MAX_KERNEL + kc][ch] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_en) begin
            // only pixels that close a window go on
            s3_valid_reg <= s2_valid_reg && s2_pix_reg && s2_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en) begin
            prod_reg    <= prod_next;
            s3_last_reg <= s2_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: per kernel row sums
    // ------------------------------------------------------------------
    rowsum_t part_next [MAX_KERNEL][NUM_CH];
    rowsum_t part_reg  [MAX_KERNEL][NUM_CH];
    logic    s4_last_reg;

    always_comb begin
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                part_next[kr][ch] = '0;
                for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                    part_next[kr][ch] = part_next[kr][ch] +
                                        ROWSUM_W'(prod_reg[kr*MAX_KERNEL + kc][ch]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (s4_en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_en) begin
            part_reg    <= part_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: channel totals
    // ------------------------------------------------------------------
    sum_t sum_next [NUM_CH];
    sum_t sum_reg  [NUM_CH];
    logic s5_last_reg;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum_next[ch] = '0;
            for (int kr = 0; kr < MAX_KERNEL; kr++) begin
                sum_next[ch] = sum_next[ch] + SUM_W'(part_reg[kr][ch]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_en) begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_en) begin
            sum_reg     <= sum_next;
            s5_last_reg <= s4_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: round, clip, hold until taken
    // ------------------------------------------------------------------
    out_item_t m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && s5_valid_reg) begin
            m_item_reg.red_out    <= round_sat(sum_reg[0]);
            m_item_reg.green_out  <= round_sat(sum_reg[1]);
            m_item_reg.blue_out   <= round_sat(sum_reg[2]);
            m_item_reg.frame_last <= s5_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// File: sim/rgb_window_convolution_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_window_convolution_core: directed table, size limits, then
// random frames. Uses rwc_pkg and the core; has its own line-buffer convolution predictor.

module rgb_window_convolution_core_test;
    import rwc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake on any channel
    localparam int SETTLE_CYCLES  = 12;     // pipeline is 6 deep, pad it
    localparam int LONG_HOLD      = 400;    // one long result-side back-pressure stretch
    localparam int ITEM_TARGET    = 1850;
    localparam int PHASE_CAP      = 160;    // pixels per random setting at most
    localparam int Q_ONE          = 1 << FRAC_W;
    localparam int MAX_REPORTS    = 10;

    typedef enum bit {STEP_REG, STEP_ITEM} step_kind_t;

    // One row of the directed table: a register write or one item, with the
    // result optionally typed in by hand.
    typedef struct {
        step_kind_t              what;
        cfg_index_t              sel;
        logic [CFG_DATA_W-1:0]   val;
        in_item_t                item;
        bit                      typed;
        out_item_t               want;
    } dir_step_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_item;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgb_window_convolution_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of line rows, taps, position and regs
    // ------------------------------------------------------------------
    rgb_t                     row_mem [MAX_KERNEL][MAX_WIDTH];
    logic signed [COEF_W-1:0] taps [KSIZE];
    int unsigned              next_col;
    int unsigned              next_row;
    logic [IW_W-1:0]          reg_width;
    logic [IH_W-1:0]          reg_height;
    logic [KD_W-1:0]          reg_kw;
    logic [KD_W-1:0]          reg_kh;

    out_item_t expected_pixels [$];

    int  errors;
    int  pixels_sent;
    int  taps_sent;
    int  reg_writes;
    int  settings_seen;
    int  pixels_checked;
    int  idle_cycles;
    bit  burst;          // no random idling on either side while set
    bit  long_hold_req;  // sink does one long hold-off on its next draw

    function automatic int unsigned limit_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Q.14 accumulator -> round half up -> clip to one 8-bit component
    function automatic logic [PIX_W-1:0] to_pixel(longint s);
        longint t;
        t = s + (longint'(1) << (FRAC_W - 1));
        if (t < 0) return '0;
        t = t >>> FRAC_W;
        if (t > PIX_MAX) return '1;
        return PIX_W'(t);
    endfunction

    function automatic void apply_reg(cfg_index_t sel, logic [CFG_DATA_W-1:0] val);
        case (sel)
            CFG_IMAGE_WIDTH:   reg_width  = val[IW_W-1:0];
            CFG_IMAGE_HEIGHT:  reg_height = val[IH_W-1:0];
            CFG_KERNEL_WIDTH:  reg_kw     = val[KD_W-1:0];
            CFG_KERNEL_HEIGHT: reg_kh     = val[KD_W-1:0];
            default: ;
        endcase
        // any write restarts the frame
        next_col = 0;
        next_row = 0;
    endfunction

    // Advance the predictor by one accepted item; flags whether it yields a pixel.
    task automatic filter_step(input in_item_t it, output bit produced, output out_item_t px);
        int unsigned w, h, fw, fh, c, r, r0, c0;
        longint      acc [3];
        bit          last;
        produced = 1'b0;
        px       = '0;
        if (it.kind == KIND_COEF) begin
            // out-of-range tap index is dropped; no effect on position
            if (it.coef_index < KSIZE) taps[it.coef_index] = it.coef_value;
            return;
        end

        w  = limit_to(reg_width, 1, MAX_WIDTH);
        h  = limit_to(reg_height, 1, MAX_HEIGHT);
        fw = limit_to(reg_kw, 1, MAX_KERNEL);
        fh = limit_to(reg_kh, 1, MAX_KERNEL);
        if (fw > w) fw = w;
        if (fh > h) fh = h;

        c = (next_col >= w) ? w - 1 : next_col;
        r = (next_row >= h) ? h - 1 : next_row;
        row_mem[r % MAX_KERNEL][c] = {it.blue_in, it.green_in, it.red_in};

        last = (c + 1 == w) && (r + 1 == h);
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
            next_row = r;
        end

        // window not yet full
        if (r + 1 < fh || c + 1 < fw) return;

        r0  = r + 1 - fh;
        c0  = c + 1 - fw;
        acc = '{0, 0, 0};
        for (int unsigned kr = 0; kr < fh; kr++) begin
            for (int unsigned kc = 0; kc < fw; kc++) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    acc[ch] += longint'(taps[kr * MAX_KERNEL + kc])
                             * longint'(row_mem[(r0 + kr) % MAX_KERNEL][c0 + kc][ch]);
                end
            end
        end
        px.red_out    = to_pixel(acc[0]);
        px.green_out  = to_pixel(acc[1]);
        px.blue_out   = to_pixel(acc[2]);
        px.frame_last = last;
        produced      = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Item builders and random draws
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        if (burst) return 0;
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 11);
        return 0;
    endfunction

    function automatic logic [PIX_W-1:0] draw_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, PIX_MAX));
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] draw_tap(int style);
        case (style)
            0:       return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
            1:       return COEF_W'($urandom);
            2:       return COEF_W'($urandom_range(0, 4000));   // smoothing-like
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return '0;
                    default: return COEF_W'(Q_ONE);
                endcase
            end
        endcase
    endfunction

    // don't-care fields carry random bits
    function automatic in_item_t coef_item(int idx, logic [COEF_W-1:0] val);
        in_item_t it;
        it.kind       = KIND_COEF;
        it.coef_index = KIDX_W'(idx);
        it.coef_value = val;
        it.red_in     = PIX_W'($urandom);
        it.green_in   = PIX_W'($urandom);
        it.blue_in    = PIX_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t pixel_item(int r, int g, int b);
        in_item_t it;
        it.kind       = KIND_PIXEL;
        it.coef_index = KIDX_W'($urandom);
        it.coef_value = COEF_W'($urandom);
        it.red_in     = PIX_W'(r);
        it.green_in   = PIX_W'(g);
        it.blue_in    = PIX_W'(b);
        return it;
    endfunction

    // upper data bits beyond the register width are junk half the time
    function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int bits);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 1) == 0) return CFG_DATA_W'(v);
        return (junk << bits) | CFG_DATA_W'(v);
    endfunction

    function automatic dir_step_t reg_row(cfg_index_t sel, int val);
        dir_step_t s;
        s.what  = STEP_REG;
        s.sel   = sel;
        s.val   = CFG_DATA_W'(val);
        s.item  = '0;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic dir_step_t item_row(in_item_t it);
        dir_step_t s;
        s.what  = STEP_ITEM;
        s.sel   = CFG_IMAGE_WIDTH;
        s.val   = '0;
        s.item  = it;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic dir_step_t want_row(in_item_t it, int r, int g, int b, bit last);
        dir_step_t s;
        s                 = item_row(it);
        s.typed           = 1'b1;
        s.want.red_out    = PIX_W'(r);
        s.want.green_out  = PIX_W'(g);
        s.want.blue_out   = PIX_W'(b);
        s.want.frame_last = last;
        return s;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Channel drivers. Inputs move on the falling edge, handshakes are seen
    // on the rising edge. Valid is left high after an item goes in; the next
    // call either reuses it or drops it on the following falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        bit        produced;
        out_item_t px;
        int        gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        filter_step(it, produced, px);
        if (produced) expected_pixels.push_back(typed ? want : px);
        if (it.kind == KIND_PIXEL) pixels_sent++;
        else if (it.coef_index < KSIZE) taps_sent++;
    endtask

    task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(sel, val);
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, let every pending pixel come out, then cover any
    // trailing coefficient item still in the pipe.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input int w, input int h, input int fw, input int fh);
        wait_for_idle();
        write_reg(CFG_IMAGE_WIDTH,   with_junk(w, IW_W));
        write_reg(CFG_IMAGE_HEIGHT,  with_junk(h, IH_W));
        write_reg(CFG_KERNEL_WIDTH,  with_junk(fw, KD_W));
        write_reg(CFG_KERNEL_HEIGHT, with_junk(fh, KD_W));
        settings_seen++;
    endtask

    task automatic load_kernel(input int style);
        for (int i = 0; i < KSIZE; i++) begin
            send_item(coef_item(i, draw_tap(style)), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random ready, one long hold-off on request, checks each
    // item against the oldest expectation.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int        gap;
        out_item_t want;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = pick_gap();
            end
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_pixels.size() == 0) begin
                note_error($sformatf("unexpected pixel r=%0d g=%0d b=%0d last=%0b",
                    m_item.red_out, m_item.green_out, m_item.blue_out, m_item.frame_last));
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_item.red_out !== want.red_out || m_item.green_out !== want.green_out ||
                    m_item.blue_out !== want.blue_out ||
                    m_item.frame_last !== want.frame_last) begin
                    note_error($sformatf(
                        "pixel %0d: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                        pixels_checked, want.red_out, want.green_out, want.blue_out,
                        want.frame_last, m_item.red_out, m_item.green_out, m_item.blue_out,
                        m_item.frame_last));
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    initial idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d pixels pending",
                     WATCHDOG_LIMIT, expected_pixels.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_step_t   plan [$];
        int          w, h, fw, fh, style, npix;
        int unsigned ew, eh;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        burst         = 1'b0;
        long_hold_req = 1'b0;
        errors = 0; pixels_sent = 0; taps_sent = 0; reg_writes = 0;
        settings_seen = 0; pixels_checked = 0;

        // predictor comes out of reset like the core
        reg_width  = IMAGE_WIDTH_RST;
        reg_height = IMAGE_HEIGHT_RST;
        reg_kw     = KERNEL_WIDTH_RST;
        reg_kh     = KERNEL_HEIGHT_RST;
        next_col   = 0;
        next_row   = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every tap gets a value before any pixel: unity tap 0, small rest
        for (int i = 0; i < KSIZE; i++) begin
            send_item(coef_item(i, (i == 0) ? COEF_W'(Q_ONE) : draw_tap(0)), 1'b0, '0);
        end

        // -------- directed table --------
        // 2x2 image, 1x1 kernel: every pixel is a result, easy to read off
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 2));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 2));
        plan.push_back(reg_row(CFG_KERNEL_WIDTH, 1));
        plan.push_back(reg_row(CFG_KERNEL_HEIGHT, 1));
        plan.push_back(item_row(coef_item(0, COEF_W'(Q_ONE))));
        plan.push_back(want_row(pixel_item(0, 255, 128), 0, 255, 128, 0));
        // tap indexes past the kernel are dropped
        plan.push_back(item_row(coef_item(25, '0)));
        plan.push_back(item_row(coef_item(31, '0)));
        plan.push_back(want_row(pixel_item(1, 2, 3), 1, 2, 3, 0));
        // largest positive tap saturates high
        plan.push_back(item_row(coef_item(0, 16'h7fff)));
        plan.push_back(want_row(pixel_item(255, 128, 1), 255, 255, 2, 0));
        // most negative tap clips to zero; last pixel of frame
        plan.push_back(item_row(coef_item(0, 16'h8000)));
        plan.push_back(want_row(pixel_item(255, 0, 1), 0, 0, 0, 1));
        // one half: rounding half up
        plan.push_back(item_row(coef_item(0, 16'h2000)));
        plan.push_back(want_row(pixel_item(1, 3, 255), 1, 2, 128, 0));
        // just under one half rounds down
        plan.push_back(item_row(coef_item(0, 16'h1fff)));
        plan.push_back(want_row(pixel_item(1, 0, 2), 0, 0, 1, 0));
        plan.push_back(item_row(coef_item(0, COEF_W'(Q_ONE))));
        plan.push_back(want_row(pixel_item(10, 20, 30), 10, 20, 30, 0));
        // register write mid-frame restarts the frame: last moves out by three
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 2));
        plan.push_back(want_row(pixel_item(40, 50, 60), 40, 50, 60, 0));
        plan.push_back(want_row(pixel_item(7, 8, 9), 7, 8, 9, 0));
        plan.push_back(want_row(pixel_item(11, 12, 13), 11, 12, 13, 0));
        plan.push_back(want_row(pixel_item(255, 255, 255), 255, 255, 255, 1));
        // kernel size above range: clamped to 5, then to the 2x2 image
        plan.push_back(reg_row(CFG_KERNEL_WIDTH, 7));
        plan.push_back(reg_row(CFG_KERNEL_HEIGHT, 7));
        plan.push_back(item_row(pixel_item(255, 0, 128)));
        plan.push_back(item_row(pixel_item(0, 255, 64)));
        plan.push_back(item_row(pixel_item(128, 128, 255)));
        plan.push_back(item_row(pixel_item(255, 255, 0)));
        // all-zero registers clamp to a 1x1 image and kernel
        plan.push_back(reg_row(CFG_IMAGE_WIDTH, 0));
        plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 0));
        plan.push_back(reg_row(CFG_KERNEL_WIDTH, 0));
        plan.push_back(reg_row(CFG_KERNEL_HEIGHT, 0));
        plan.push_back(want_row(pixel_item(200, 100, 50), 200, 100, 50, 1));
        plan.push_back(want_row(pixel_item(0, 0, 0), 0, 0, 0, 1));

        foreach (plan[i]) begin
            if (plan[i].what == STEP_REG) begin
                wait_for_idle();
                write_reg(plan[i].sel, plan[i].val);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
        end
        settings_seen += 4;

        // -------- widest row --------
        // width above range clamps to 1024, height 0 to 1 (kernel height follows).
        // Back-to-back input while the result side holds off for a long stretch,
        // so the pipe fills and input ready drops.
        configure(2047, 0, 5, 3);
        load_kernel(2);
        burst         = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            send_item(pixel_item(draw_channel(), draw_channel(), draw_channel()), 1'b0, '0);
        end
        burst = 1'b0;

        // tall setting: height clamps to 4096, only the top rows are fed
        configure(3, 8191, 2, 6);
        load_kernel(0);
        for (int i = 0; i < 24; i++) begin
            send_item(pixel_item(draw_channel(), draw_channel(), draw_channel()), 1'b0, '0);
        end

        // -------- random frames --------
        while (pixels_sent + taps_sent < ITEM_TARGET) begin
            w  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            h  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9);
            fw = $urandom_range(0, 7);
            fh = $urandom_range(0, 7);
            configure(w, h, fw, fh);
            burst = ($urandom_range(0, 3) == 0);
            style = $urandom_range(0, 3);
            if ($urandom_range(0, 1) == 0) load_kernel(style);

            ew   = limit_to(w, 1, MAX_WIDTH);
            eh   = limit_to(h, 1, MAX_HEIGHT);
            npix = $urandom_range(1, 3) * ew * eh;
            if (npix > PHASE_CAP) npix = PHASE_CAP;
            // sometimes break the frame off early
            if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);

            for (int i = 0; i < npix; i++) begin
                // occasional tap rewrite mid-frame, index may fall outside the kernel
                if ($urandom_range(0, 15) == 0) begin
                    send_item(coef_item($urandom_range(0, 31), draw_tap(style)), 1'b0, '0);
                end
                send_item(pixel_item(draw_channel(), draw_channel(), draw_channel()),
                          1'b0, '0);
            end
        end
        burst = 1'b0;

        wait_for_idle();
        if (expected_pixels.size() != 0) begin
            note_error($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
        end

        $display("Run: %0d pixels, %0d tap loads, %0d register writes over %0d settings",
                 pixels_sent, taps_sent, reg_writes, settings_seen);
        $display("     %0d filtered pixels compared, %0d mismatches", pixels_checked, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
